// ----- rtl/core/fkw_pkg.sv -----
// Shared types and codes for the keyed-withdraw queue.
package fkw_pkg;

   typedef enum logic [1:0] {
      ACT_PUSH     = 2'd0,
      ACT_POP      = 2'd1,
      ACT_WITHDRAW = 2'd2,
      ACT_NOP      = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_DONE     = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_FULL     = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   typedef struct packed {
      logic       capture;
      logic       push;
      logic       start_scan;
      logic       advance;
      logic       hit;
      logic       shift;
      logic       pop;
      logic       drop;
      logic       respond;
      status_type status;
   } cmd_type;

   typedef struct packed {
      action_type action;
      logic       empty;
      logic       full;
      logic       match;
      logic       last;
   } stat_type;

endpackage

// ----- rtl/core/fifo_with_keyed_withdraw_core.sv -----
// Top level of the ordered identifier queue with push, pop and keyed withdraw.
//
// Ordered queue of up to DEPTH identifiers kept in a circular single-port-write
// store with a registered read. Raise start with an action while busy is low;
// the transaction is taken at that edge and exactly one result follows, shown
// for one cycle with rsp_valid high, which the receiver must take as it comes.
// A push, full, empty or no-op passes through the decode state only, and a pop
// through decode and a pop-wait state; a withdraw reads the store one entry per
// cycle from the front until it finds the key, then moves each later entry
// forward one per cycle. The result appears in the first cycle with busy low,
// and a new transaction may be accepted at the edge that ends that cycle.
module fifo_with_keyed_withdraw_core #(
   parameter int DEPTH   = 16,
   parameter int ID_BITS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [1:0]                 req_action,
   input  logic [ID_BITS-1:0]         req_person_id,
   output logic                       rsp_valid,
   output logic [1:0]                 rsp_status,
   output logic [ID_BITS-1:0]         rsp_removed_id,
   output logic [$clog2(DEPTH+1)-1:0] rsp_occupancy
);
   import fkw_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type  cmd;
   stat_type stat;

   fkw_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   fkw_datapath #(
      .DEPTH   (DEPTH),
      .ID_BITS (ID_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_action     (req_action),
      .req_person_id  (req_person_id),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_removed_id (rsp_removed_id),
      .rsp_occupancy  (rsp_occupancy)
   );

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not make the block busy");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a transaction in progress");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_occupancy <= CNT_W'(DEPTH)))
      else $error("occupancy exceeds depth");

   a_full_occ: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |-> (rsp_occupancy == CNT_W'(DEPTH)))
      else $error("full reported below depth");

   a_removed_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_DONE) |-> (rsp_removed_id == '0))
      else $error("removed identifier on a failed transaction");

endmodule

// ----- rtl/core/fkw_ctrl.sv -----
// Sequencing state machine for the keyed-withdraw queue.
module fkw_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  fkw_pkg::stat_type stat,
   output fkw_pkg::cmd_type  cmd
);
   import fkw_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE     = 5'b00001,
      S_DECODE   = 5'b00010,
      S_POP_WAIT = 5'b00100,
      S_SCAN     = 5'b01000,
      S_SHIFT    = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.status = ST_DONE;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (stat.action)
               ACT_PUSH: begin
                  cmd.respond = 1'b1;
                  state_in    = S_IDLE;
                  if (stat.full) begin
                     cmd.status = ST_FULL;
                  end else begin
                     cmd.push = 1'b1;
                  end
               end
               ACT_POP: begin
                  if (stat.empty) begin
                     cmd.respond = 1'b1;
                     cmd.status  = ST_EMPTY;
                     state_in    = S_IDLE;
                  end else begin
                     cmd.start_scan = 1'b1;
                     state_in       = S_POP_WAIT;
                  end
               end
               ACT_WITHDRAW: begin
                  if (stat.empty) begin
                     cmd.respond = 1'b1;
                     cmd.status  = ST_EMPTY;
                     state_in    = S_IDLE;
                  end else begin
                     cmd.start_scan = 1'b1;
                     state_in       = S_SCAN;
                  end
               end
               ACT_NOP: begin
                  cmd.respond = 1'b1;
                  state_in    = S_IDLE;
               end
               default: begin
                  cmd.respond = 1'b1;
                  state_in    = S_IDLE;
               end
            endcase
         end
         S_POP_WAIT: begin
            cmd.pop     = 1'b1;
            cmd.respond = 1'b1;
            state_in    = S_IDLE;
         end
         S_SCAN: begin
            priority if (stat.match) begin
               cmd.hit  = 1'b1;
               state_in = S_SHIFT;
            end else if (stat.last) begin
               cmd.respond = 1'b1;
               cmd.status  = ST_NOTFOUND;
               state_in    = S_IDLE;
            end else begin
               cmd.advance = 1'b1;
            end
         end
         S_SHIFT: begin
            if (stat.last) begin
               cmd.drop    = 1'b1;
               cmd.respond = 1'b1;
               state_in    = S_IDLE;
            end else begin
               cmd.shift = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/core/fkw_datapath.sv -----
// Entry store, pointers, scan offset and result registers of the queue.
module fkw_datapath #(
   parameter int DEPTH   = 16,
   parameter int ID_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [1:0]                   req_action,
   input  logic [ID_BITS-1:0]           req_person_id,
   input  fkw_pkg::cmd_type             cmd,
   output fkw_pkg::stat_type            stat,
   output logic                         rsp_valid,
   output logic [1:0]                   rsp_status,
   output logic [ID_BITS-1:0]           rsp_removed_id,
   output logic [$clog2(DEPTH+1)-1:0]   rsp_occupancy
);
   import fkw_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);

   logic [ID_BITS-1:0] entries_ff [DEPTH];
   logic [ID_BITS-1:0] rd_data_ff;

   action_type         action_ff, action_in;
   logic [ID_BITS-1:0] id_ff, id_in;
   logic [ID_BITS-1:0] removed_ff, removed_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   head_ff, head_in;
   logic [CNT_W-1:0]   off_ff, off_in;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [ID_BITS-1:0] rsp_removed_ff, rsp_removed_in;
   logic [CNT_W-1:0]   rsp_occ_ff, rsp_occ_in;

   logic [CNT_W:0]     rd_off;
   logic [IDX_W-1:0]   rd_addr;
   logic [IDX_W-1:0]   wr_addr;
   logic [ID_BITS-1:0] wr_data;
   logic               wr_en;

   function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                             input logic [CNT_W:0] off);
      logic [CNT_W+1:0] s;
      s = (CNT_W+2)'(head) + (CNT_W+2)'(off);
      if (s >= (CNT_W+2)'(DEPTH)) begin
         s = s - (CNT_W+2)'(DEPTH);
      end
      if (s >= (CNT_W+2)'(DEPTH)) begin
         s = '0;
      end
      return s[IDX_W-1:0];
   endfunction

   always_comb begin
      priority if (cmd.start_scan) begin
         rd_off = '0;
      end else if (cmd.shift) begin
         rd_off = (CNT_W+1)'(off_ff) + (CNT_W+1)'(2);
      end else begin
         rd_off = (CNT_W+1)'(off_ff) + (CNT_W+1)'(1);
      end
      rd_addr = phys(head_ff, rd_off);
      wr_en   = cmd.push | cmd.shift;
      wr_addr = cmd.push ? phys(head_ff, (CNT_W+1)'(count_ff))
                         : phys(head_ff, (CNT_W+1)'(off_ff));
      wr_data = cmd.push ? id_ff : rd_data_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= entries_ff[rd_addr];
   end

   always_comb begin
      action_in  = action_ff;
      id_in      = id_ff;
      removed_in = removed_ff;
      count_in   = count_ff;
      head_in    = head_ff;
      off_in     = off_ff;
      if (cmd.capture) begin
         action_in  = action_type'(req_action);
         id_in      = req_person_id;
         removed_in = '0;
      end
      if (cmd.start_scan) begin
         off_in = '0;
      end
      if (cmd.advance || cmd.shift) begin
         off_in = off_ff + CNT_W'(1);
      end
      if (cmd.hit) begin
         removed_in = rd_data_ff;
      end
      if (cmd.push) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.pop || cmd.drop) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (cmd.pop) begin
         head_in = (head_ff == IDX_W'(DEPTH - 1)) ? '0 : head_ff + IDX_W'(1);
      end
      rsp_valid_in   = cmd.respond;
      rsp_status_in  = cmd.status;
      rsp_removed_in = cmd.pop ? rd_data_ff : removed_ff;
      rsp_occ_in     = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         head_ff      <= '0;
         off_ff       <= '0;
         action_ff    <= ACT_NOP;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         head_ff      <= head_in;
         off_ff       <= off_in;
         action_ff    <= action_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff          <= id_in;
      removed_ff     <= removed_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_occ_ff     <= rsp_occ_in;
   end

   always_comb begin
      stat.action = action_ff;
      stat.empty  = (count_ff == '0);
      stat.full   = (count_ff == CNT_W'(DEPTH));
      stat.match  = (rd_data_ff == id_ff);
      stat.last   = ((off_ff + CNT_W'(1)) == count_ff);
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_removed_id = rsp_removed_ff;
   assign rsp_occupancy  = rsp_occ_ff;

endmodule
